// ===== hw/rtl/rclm_pkg.sv =====
// ----------------------------------------------------------------------------
// rclm_pkg
// Shared sizes, request and status codes and the dedup status struct for the
// region contour list merge core.
// ----------------------------------------------------------------------------
package rclm_pkg;

  localparam int ID_W   = 16;
  localparam int SPAN_W = 24;
  localparam int IDX_W  = 5;
  localparam int N_MAX  = 32;
  localparam int O_MAX  = 16;

  localparam int NIDX_W  = $clog2(N_MAX);
  localparam int OIDX_W  = $clog2(O_MAX);
  localparam int NCNT_W  = $clog2(N_MAX + 1);
  localparam int OLEN_W  = $clog2(O_MAX + 1);
  localparam int TIDX_W  = $clog2(2 * N_MAX);
  localparam int TCNT_W  = $clog2(2 * N_MAX);
  localparam int OTIDX_W = $clog2(2 * O_MAX);
  localparam int OCNT_W  = $clog2(2 * O_MAX + 1);
  localparam int POS_A   = $clog2(2 * N_MAX + 1);
  localparam int POS_B   = $clog2(2 * O_MAX + 1);
  localparam int POS_W   = (POS_A > POS_B) ? POS_A : POS_B;

  localparam logic [2:0] REQ_RESET   = 3'd0;
  localparam logic [2:0] REQ_ADD_NB  = 3'd1;
  localparam logic [2:0] REQ_ADD_OV  = 3'd2;
  localparam logic [2:0] REQ_SPANS   = 3'd3;
  localparam logic [2:0] REQ_TEST    = 3'd4;
  localparam logic [2:0] REQ_MERGE   = 3'd5;
  localparam logic [2:0] REQ_REPLACE = 3'd6;
  localparam logic [2:0] REQ_READ    = 3'd7;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOCONN = 2'd1;
  localparam logic [1:0] ST_CAP    = 2'd2;

  typedef struct packed {
    logic              emit;
    logic              drop;
    logic [TCNT_W-1:0] cnt;
  } dedup_t;

endpackage

// ===== hw/rtl/rclm_dedup.sv =====
// ----------------------------------------------------------------------------
// rclm_dedup
// Streaming circular duplicate filter: collapses runs of equal ids and flags
// a wrap-around match between the last and the first kept id.
// ----------------------------------------------------------------------------
module rclm_dedup (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    clear,
  input  logic                    push,
  input  logic [rclm_pkg::ID_W-1:0] din,
  output rclm_pkg::dedup_t        st
);
  import rclm_pkg::*;

  logic [ID_W-1:0]   first_id;
  logic [ID_W-1:0]   last_id;
  logic [TCNT_W-1:0] cnt;

  assign st.emit = push && ((cnt == '0) || (din != last_id));
  assign st.drop = (cnt > TCNT_W'(1)) && (last_id == first_id);
  assign st.cnt  = cnt;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      cnt <= '0;
    end else if (st.emit) begin
      cnt <= cnt + TCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (st.emit) begin
      last_id <= din;
      if (cnt == '0) begin
        first_id <= din;
      end
    end
  end

endmodule

// ===== hw/rtl/region_contour_list_merge_core.sv =====
// One item at a time; every list step is an address state followed by a data state on a single read port.
// Reset (synchronous, active high) clears ids, span counts and list lengths.
// ----------------------------------------------------------------------------
// region_contour_list_merge_core
// Two region records with circular neighbour lists and overlap lists, under a
// small sequencer that tests, merges, replaces and reads them.
// ----------------------------------------------------------------------------
module region_contour_list_merge_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata: value[15:0], new_value[31:16], span_value[55:32], index[60:56]
  input  logic [63:0] s_tdata,
  // s_tuser: req_type[2:0], side[3], list_sel[4]
  input  logic [4:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata: status[1:0], data[17:2], neighbour_count[23:18],
  //          overlap_count[28:24], span_total[52:29]
  output logic [55:0] m_tdata
);
  import rclm_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0,  S_EXEC = 5'd1,  S_RD_A = 5'd2,  S_RD_B = 5'd3;
  localparam logic [4:0] S_SCAN_A = 5'd4, S_SCAN_B = 5'd5, S_T2 = 5'd6, S_T3 = 5'd7;
  localparam logic [4:0] S_T4 = 5'd8,  S_M2 = 5'd9,  S_M3 = 5'd10, S_MS_A = 5'd11;
  localparam logic [4:0] S_MS_B = 5'd12, S_M4 = 5'd13, S_OC_A = 5'd14, S_OC_B = 5'd15;
  localparam logic [4:0] S_OU_A = 5'd16, S_OU_B = 5'd17, S_OU_C = 5'd18, S_M5 = 5'd19;
  localparam logic [4:0] S_NC_A = 5'd20, S_NC_B = 5'd21, S_OW_A = 5'd22, S_OW_B = 5'd23;
  localparam logic [4:0] S_RN_A = 5'd24, S_RN_B = 5'd25, S_RO_A = 5'd26, S_RO_B = 5'd27;
  localparam logic [4:0] S_DONE = 5'd28;

  localparam logic [1:0] MEM_N = 2'd0, MEM_O = 2'd1, MEM_NT = 2'd2, MEM_OT = 2'd3;

  // Record state.
  logic [ID_W-1:0]   rid   [2];
  logic [SPAN_W-1:0] spans [2];
  logic [NCNT_W-1:0] nlen  [2];
  logic [OLEN_W-1:0] olen  [2];

  // List storage and merge scratch buffers.
  logic [ID_W-1:0] nmem [2*N_MAX];
  logic [ID_W-1:0] omem [2*O_MAX];
  logic [ID_W-1:0] ntmp [2*N_MAX];
  logic [ID_W-1:0] otmp [2*O_MAX];
  logic [ID_W-1:0] n_rdata, o_rdata, nt_rdata, ot_rdata;

  logic              n_we, o_we, nt_we, ot_we;
  logic [TIDX_W-1:0] n_waddr, nt_waddr;
  logic [OIDX_W:0]   o_waddr;
  logic [OTIDX_W-1:0] ot_waddr;
  logic [ID_W-1:0]   n_wdata, o_wdata, nt_wdata, ot_wdata;
  logic [POS_W-1:0]  o_ridx;

  // Captured item.
  logic [2:0]        req_q;
  logic              side_q, sel_q;
  logic [ID_W-1:0]   val_q, nval_q;
  logic [SPAN_W-1:0] span_q;
  logic [IDX_W-1:0]  idx_q;

  // Sequencer.
  logic [4:0]        state, ret;
  logic [1:0]        msel;
  logic              rs, phase, changed;
  logic [POS_W-1:0]  pos, k, scan_len, hitpos, pt_q, pc_q;
  logic [1:0]        hits;
  logic [ID_W-1:0]   key;
  logic [OLEN_W-1:0] j;
  logic [OCNT_W-1:0] oc;
  logic [1:0]        stat_q;
  logic [ID_W-1:0]   data_q;

  logic [ID_W-1:0]   rdata_sel;
  logic              eq;
  logic              oth;
  logic              dclr, dpush;
  logic [ID_W-1:0]   ddin;
  dedup_t            dst;
  logic [TCNT_W-1:0] fin;
  logic [SPAN_W:0]   span_sum;
  logic [SPAN_W-1:0] span_sat;

  function automatic logic [POS_W-1:0] wrap_inc(input logic [POS_W-1:0] p,
                                                input logic [NCNT_W-1:0] n);
    logic [POS_W-1:0] inc;
    inc = p + POS_W'(1);
    return (inc == POS_W'(n)) ? '0 : inc;
  endfunction

  assign oth      = ~side_q;
  assign s_tready = (state == S_IDLE);
  assign fin      = dst.cnt - TCNT_W'(dst.drop);
  assign span_sum = {1'b0, spans[0]} + {1'b0, spans[1]};
  assign span_sat = span_sum[SPAN_W] ? {SPAN_W{1'b1}} : span_sum[SPAN_W-1:0];

  // The one shared id comparator: selected read data against the key.
  always_comb begin
    unique case (msel)
      MEM_N:   rdata_sel = n_rdata;
      MEM_O:   rdata_sel = o_rdata;
      MEM_NT:  rdata_sel = nt_rdata;
      default: rdata_sel = ot_rdata;
    endcase
  end
  assign eq = (rdata_sel == key);

  // Duplicate filter feeding the neighbour scratch buffer.
  assign dclr  = (state == S_M3) || (state == S_EXEC && req_q == REQ_REPLACE);
  assign dpush = (state == S_MS_B) || (state == S_RN_B);
  assign ddin  = (state == S_RN_B && eq) ? nval_q : n_rdata;

  rclm_dedup u_dedup (
    .clk   (clk),
    .rst   (rst),
    .clear (dclr),
    .push  (dpush),
    .din   (ddin),
    .st    (dst)
  );

  // Write ports.
  always_comb begin
    n_we    = 1'b0;
    n_waddr = {side_q, k[NIDX_W-1:0]};
    n_wdata = nt_rdata;
    if (state == S_EXEC && req_q == REQ_ADD_NB && nlen[side_q] < NCNT_W'(N_MAX)) begin
      n_we    = 1'b1;
      n_waddr = {side_q, nlen[side_q][NIDX_W-1:0]};
      n_wdata = val_q;
    end else if (state == S_NC_B) begin
      n_we = 1'b1;
    end
  end

  always_comb begin
    o_we    = 1'b0;
    o_waddr = {side_q, pos[OIDX_W-1:0]};
    o_wdata = ot_rdata;
    if (state == S_EXEC && req_q == REQ_ADD_OV && olen[side_q] < OLEN_W'(O_MAX)) begin
      o_we    = 1'b1;
      o_waddr = {side_q, olen[side_q][OIDX_W-1:0]};
      o_wdata = val_q;
    end else if (state == S_RO_B && eq) begin
      o_we    = 1'b1;
      o_wdata = nval_q;
    end else if (state == S_OW_B) begin
      o_we = 1'b1;
    end
  end

  assign nt_we    = dst.emit;
  assign nt_waddr = dst.cnt[TIDX_W-1:0];
  assign nt_wdata = ddin;

  always_comb begin
    ot_we    = 1'b0;
    ot_waddr = pos[OTIDX_W-1:0];
    ot_wdata = o_rdata;
    if (state == S_OC_B) begin
      ot_we = 1'b1;
    end else if (state == S_OU_C && hits == 2'd0) begin
      ot_we    = 1'b1;
      ot_waddr = oc[OTIDX_W-1:0];
      ot_wdata = key;
    end
  end

  assign o_ridx = (state == S_OU_A || state == S_OU_B) ? POS_W'(j) : pos;

  always_ff @(posedge clk) begin
    if (n_we)  nmem[n_waddr]  <= n_wdata;
    if (o_we)  omem[o_waddr]  <= o_wdata;
    if (nt_we) ntmp[nt_waddr] <= nt_wdata;
    if (ot_we) otmp[ot_waddr] <= ot_wdata;
    n_rdata  <= nmem[{rs, pos[NIDX_W-1:0]}];
    o_rdata  <= omem[{rs, o_ridx[OIDX_W-1:0]}];
    nt_rdata <= ntmp[pos[TIDX_W-1:0]];
    ot_rdata <= otmp[pos[OTIDX_W-1:0]];
  end

  // Output register: a finished result waits here while the core goes back to idle.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {3'd0, spans[side_q], olen[side_q], nlen[side_q], data_q, stat_q};
    end
  end

  // Sequencer and record state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rid[0]  <= '0;
      rid[1]  <= '0;
      spans[0] <= '0;
      spans[1] <= '0;
      nlen[0] <= '0;
      nlen[1] <= '0;
      olen[0] <= '0;
      olen[1] <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            req_q  <= s_tuser[2:0];
            side_q <= s_tuser[3];
            sel_q  <= s_tuser[4];
            val_q  <= s_tdata[15:0];
            nval_q <= s_tdata[31:16];
            span_q <= s_tdata[55:32];
            idx_q  <= s_tdata[60:56];
            stat_q <= ST_OK;
            data_q <= '0;
            state  <= S_EXEC;
          end
        end

        S_EXEC: begin
          unique case (req_q)
            REQ_RESET: begin
              rid[side_q]   <= val_q;
              spans[side_q] <= '0;
              nlen[side_q]  <= '0;
              olen[side_q]  <= '0;
              state <= S_DONE;
            end
            REQ_ADD_NB: begin
              if (nlen[side_q] < NCNT_W'(N_MAX)) nlen[side_q] <= nlen[side_q] + NCNT_W'(1);
              else stat_q <= ST_CAP;
              state <= S_DONE;
            end
            REQ_ADD_OV: begin
              if (olen[side_q] < OLEN_W'(O_MAX)) olen[side_q] <= olen[side_q] + OLEN_W'(1);
              else stat_q <= ST_CAP;
              state <= S_DONE;
            end
            REQ_SPANS: begin
              spans[side_q] <= span_q;
              state <= S_DONE;
            end
            REQ_TEST, REQ_MERGE: begin
              msel     <= MEM_N;
              rs       <= side_q;
              key      <= rid[oth];
              scan_len <= POS_W'(nlen[side_q]);
              pos      <= '0;
              hits     <= 2'd0;
              ret      <= (req_q == REQ_TEST) ? S_T2 : S_M2;
              state    <= S_SCAN_A;
            end
            REQ_REPLACE: begin
              msel    <= MEM_N;
              rs      <= side_q;
              key     <= val_q;
              pos     <= '0;
              changed <= 1'b0;
              state   <= S_RN_A;
            end
            default: begin
              rs  <= side_q;
              pos <= POS_W'(idx_q);
              if (!sel_q && POS_W'(idx_q) < POS_W'(nlen[side_q])) begin
                msel  <= MEM_N;
                state <= S_RD_A;
              end else if (sel_q && POS_W'(idx_q) < POS_W'(olen[side_q])) begin
                msel  <= MEM_O;
                state <= S_RD_A;
              end else begin
                state <= S_DONE;
              end
            end
          endcase
        end

        S_RD_A: state <= S_RD_B;
        S_RD_B: begin
          data_q <= rdata_sel;
          state  <= S_DONE;
        end

        // Generic scan: count matches of key (saturating at two), note the first.
        S_SCAN_A: state <= (pos == scan_len) ? ret : S_SCAN_B;
        S_SCAN_B: begin
          if (eq) begin
            if (hits == 2'd0) hitpos <= pos;
            if (hits != 2'd2) hits <= hits + 2'd1;
          end
          pos   <= pos + POS_W'(1);
          state <= S_SCAN_A;
        end

        // Mergeability test.
        S_T2: begin
          if (hits != 2'd1) begin
            stat_q <= ST_NOCONN;
            state  <= S_DONE;
          end else begin
            msel     <= MEM_O;
            rs       <= side_q;
            scan_len <= POS_W'(olen[side_q]);
            pos      <= '0;
            hits     <= 2'd0;
            ret      <= S_T3;
            state    <= S_SCAN_A;
          end
        end
        S_T3: begin
          if (hits != 2'd0) begin
            stat_q <= ST_NOCONN;
            state  <= S_DONE;
          end else begin
            rs       <= oth;
            key      <= rid[side_q];
            scan_len <= POS_W'(olen[oth]);
            pos      <= '0;
            hits     <= 2'd0;
            ret      <= S_T4;
            state    <= S_SCAN_A;
          end
        end
        S_T4: begin
          if (hits != 2'd0) stat_q <= ST_NOCONN;
          state <= S_DONE;
        end

        // Merge: find both contacts.
        S_M2: begin
          if (hits == 2'd0) begin
            stat_q <= ST_NOCONN;
            state  <= S_DONE;
          end else begin
            pt_q     <= hitpos;
            rs       <= oth;
            key      <= rid[side_q];
            scan_len <= POS_W'(nlen[oth]);
            pos      <= '0;
            hits     <= 2'd0;
            ret      <= S_M3;
            state    <= S_SCAN_A;
          end
        end
        S_M3: begin
          if (hits == 2'd0) begin
            stat_q <= ST_NOCONN;
            state  <= S_DONE;
          end else begin
            pc_q  <= hitpos;
            rs    <= side_q;
            pos   <= wrap_inc(pt_q, nlen[side_q]);
            k     <= '0;
            phase <= 1'b0;
            state <= S_MS_A;
          end
        end

        // Splice both rotated lists through the duplicate filter.
        S_MS_A: begin
          if (k == (phase ? POS_W'(nlen[oth]) : POS_W'(nlen[side_q])) - POS_W'(1)) begin
            if (!phase) begin
              phase <= 1'b1;
              rs    <= oth;
              pos   <= wrap_inc(pc_q, nlen[oth]);
              k     <= '0;
            end else begin
              state <= S_M4;
            end
          end else begin
            state <= S_MS_B;
          end
        end
        S_MS_B: begin
          pos   <= wrap_inc(pos, nlen[rs]);
          k     <= k + POS_W'(1);
          state <= S_MS_A;
        end

        S_M4: begin
          if (fin > TCNT_W'(N_MAX)) begin
            stat_q <= ST_CAP;
            state  <= S_DONE;
          end else begin
            rs    <= side_q;
            pos   <= '0;
            state <= S_OC_A;
          end
        end

        // Overlap union built in scratch: own list, then new ids of the other.
        S_OC_A: begin
          if (pos == POS_W'(olen[side_q])) begin
            oc    <= OCNT_W'(olen[side_q]);
            j     <= '0;
            rs    <= oth;
            state <= S_OU_A;
          end else begin
            state <= S_OC_B;
          end
        end
        S_OC_B: begin
          pos   <= pos + POS_W'(1);
          state <= S_OC_A;
        end
        S_OU_A: state <= (j == olen[oth]) ? S_M5 : S_OU_B;
        S_OU_B: begin
          key      <= o_rdata;
          msel     <= MEM_OT;
          scan_len <= POS_W'(oc);
          pos      <= '0;
          hits     <= 2'd0;
          ret      <= S_OU_C;
          state    <= S_SCAN_A;
        end
        S_OU_C: begin
          if (hits == 2'd0) oc <= oc + OCNT_W'(1);
          j     <= j + OLEN_W'(1);
          state <= S_OU_A;
        end

        S_M5: begin
          if (oc > OCNT_W'(O_MAX)) begin
            stat_q <= ST_CAP;
            state  <= S_DONE;
          end else begin
            pos   <= POS_W'(dst.drop);
            k     <= '0;
            state <= S_NC_A;
          end
        end

        // Copy the filtered neighbour list back, skipping a wrapped duplicate.
        S_NC_A: begin
          if (k == POS_W'(fin)) begin
            nlen[side_q] <= fin[NCNT_W-1:0];
            pos   <= '0;
            rs    <= side_q;
            msel  <= MEM_O;
            state <= (req_q == REQ_MERGE) ? S_OW_A : S_RO_A;
          end else begin
            state <= S_NC_B;
          end
        end
        S_NC_B: begin
          pos   <= pos + POS_W'(1);
          k     <= k + POS_W'(1);
          state <= S_NC_A;
        end

        S_OW_A: begin
          if (pos == POS_W'(oc)) begin
            olen[side_q]  <= oc[OLEN_W-1:0];
            spans[side_q] <= span_sat;
            state <= S_DONE;
          end else begin
            state <= S_OW_B;
          end
        end
        S_OW_B: begin
          pos   <= pos + POS_W'(1);
          state <= S_OW_A;
        end

        // Replace: neighbours go through the filter, overlaps are patched in place.
        S_RN_A: begin
          if (pos == POS_W'(nlen[side_q])) begin
            if (changed) begin
              pos   <= POS_W'(dst.drop);
              k     <= '0;
              state <= S_NC_A;
            end else begin
              pos   <= '0;
              msel  <= MEM_O;
              state <= S_RO_A;
            end
          end else begin
            state <= S_RN_B;
          end
        end
        S_RN_B: begin
          if (eq) changed <= 1'b1;
          pos   <= pos + POS_W'(1);
          state <= S_RN_A;
        end
        S_RO_A: state <= (pos == POS_W'(olen[side_q])) ? S_DONE : S_RO_B;
        S_RO_B: begin
          pos   <= pos + POS_W'(1);
          state <= S_RO_A;
        end

        S_DONE: begin
          if (!m_tvalid || m_tready) state <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== dv/region_contour_list_merge_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_contour_list_merge_core_tb
// Drives request items into the region merge core, predicts every response
// with a behavioral copy of both region records, and checks each returned
// item field by field under several idle and stall patterns.
// ----------------------------------------------------------------------------
module region_contour_list_merge_core_tb;
  import rclm_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] data;
    logic [5:0]  nb_count;
    logic [4:0]  ov_count;
    logic [23:0] spans;
  } resp_t;

  // Behavioral copy of the two region records plus the queue of responses
  // that the core still owes us.
  class region_scoreboard;
    logic [15:0] rid [2];
    logic [23:0] span [2];
    logic [15:0] nb [2][$];
    logic [15:0] ov [2][$];
    resp_t       pending [$];
    int          errors;

    function new();
      errors = 0;
      for (int s = 0; s < 2; s++) begin
        rid[s] = '0;
        span[s] = '0;
        nb[s].delete();
        ov[s].delete();
      end
    endfunction

    // Remove circularly adjacent duplicates, scanning from the front.
    function void squash_ring(ref logic [15:0] a[$]);
      int i;
      int j;
      i = 0;
      while (i < a.size() && a.size() > 1) begin
        j = (i + 1 >= a.size()) ? 0 : i + 1;
        if (a[i] == a[j]) a.delete(j);
        else i++;
      end
    endfunction

    function int count_of(logic [15:0] a[$], logic [15:0] id);
      int n;
      n = 0;
      foreach (a[i]) if (a[i] == id) n++;
      return n;
    endfunction

    function int first_pos(logic [15:0] a[$], logic [15:0] id);
      foreach (a[i]) if (a[i] == id) return i;
      return -1;
    endfunction

    function logic [1:0] try_merge(int t);
      int c;
      int pt;
      int pc;
      logic [15:0] ring [$];
      logic [15:0] uni [$];
      logic [24:0] sum;
      c = 1 - t;
      pt = first_pos(nb[t], rid[c]);
      pc = first_pos(nb[c], rid[t]);
      if (pt < 0 || pc < 0) return ST_NOCONN;
      for (int i = 0; i + 1 < nb[t].size(); i++)
        ring.push_back(nb[t][(pt + 1 + i) % nb[t].size()]);
      for (int i = 0; i + 1 < nb[c].size(); i++)
        ring.push_back(nb[c][(pc + 1 + i) % nb[c].size()]);
      squash_ring(ring);
      if (ring.size() > N_MAX) return ST_CAP;
      uni = ov[t];
      foreach (ov[c][i]) if (first_pos(uni, ov[c][i]) < 0) uni.push_back(ov[c][i]);
      if (uni.size() > O_MAX) return ST_CAP;
      nb[t] = ring;
      ov[t] = uni;
      sum = span[t] + span[c];
      span[t] = sum[24] ? 24'hFFFFFF : sum[23:0];
      return ST_OK;
    endfunction

    // Apply one accepted request and queue the response it must produce.
    function void note_request(logic [2:0] req, int s, logic sel, logic [15:0] val,
                               logic [15:0] nval, logic [23:0] spv, logic [4:0] idx);
      resp_t r;
      bit changed;
      int o;
      o = 1 - s;
      r = '0;
      case (req)
        REQ_RESET: begin
          rid[s] = val;
          span[s] = '0;
          nb[s].delete();
          ov[s].delete();
        end
        REQ_ADD_NB: if (nb[s].size() < N_MAX) nb[s].push_back(val); else r.status = ST_CAP;
        REQ_ADD_OV: if (ov[s].size() < O_MAX) ov[s].push_back(val); else r.status = ST_CAP;
        REQ_SPANS: span[s] = spv;
        REQ_TEST: begin
          if (count_of(nb[s], rid[o]) != 1 || first_pos(ov[s], rid[o]) >= 0 ||
              first_pos(ov[o], rid[s]) >= 0) r.status = ST_NOCONN;
        end
        REQ_MERGE: r.status = try_merge(s);
        REQ_REPLACE: begin
          changed = 0;
          foreach (nb[s][i]) if (nb[s][i] == val) begin
            nb[s][i] = nval;
            changed = 1;
          end
          foreach (ov[s][i]) if (ov[s][i] == val) ov[s][i] = nval;
          if (changed) squash_ring(nb[s]);
        end
        default: begin
          if (!sel && idx < nb[s].size()) r.data = nb[s][idx];
          if (sel && idx < ov[s].size()) r.data = ov[s][idx];
        end
      endcase
      r.nb_count = 6'(nb[s].size());
      r.ov_count = 5'(ov[s].size());
      r.spans = span[s];
      pending.push_back(r);
    endfunction

    function void check_response(logic [55:0] word);
      resp_t e;
      resp_t a;
      a = {word[1:0], word[17:2], word[23:18], word[28:24], word[52:29]};
      if (pending.size() == 0) begin
        $error("response with no request outstanding: %h", word);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.status != e.status) begin
        $error("status expected %0d got %0d", e.status, a.status); errors++;
      end
      if (a.data != e.data) begin
        $error("data expected %0h got %0h", e.data, a.data); errors++;
      end
      if (a.nb_count != e.nb_count) begin
        $error("neighbour_count expected %0d got %0d", e.nb_count, a.nb_count); errors++;
      end
      if (a.ov_count != e.ov_count) begin
        $error("overlap_count expected %0d got %0d", e.ov_count, a.ov_count); errors++;
      end
      if (a.spans != e.spans) begin
        $error("span_total expected %0h got %0h", e.spans, a.spans); errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic [4:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;

  region_scoreboard sb;
  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_cycles;
  int  sent_items;
  int  phase_end;
  bit  held;
  logic [15:0] id_pool [4];

  region_contour_list_merge_core u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Receiver: random stalls, plus a long hold-off whenever hold_cycles is set.
  always @(posedge clk) begin
    if (m_tvalid && m_tready && !rst) sb.check_response(m_tdata);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one request item; the random idle gap comes before it is raised.
  // tvalid stays up after the accept until the next gap, item or drain.
  task automatic send_req(logic [2:0] req, bit s, bit sel, logic [15:0] val,
                          logic [15:0] nval, logic [23:0] spv, logic [4:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b0, idx, spv, nval, val};
    s_tuser  <= {sel, s, req};
    do @(posedge clk); while (!s_tready);
    sb.note_request(req, s, sel, val, nval, spv, idx);
    sent_items++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_id();
    return ($urandom_range(9) == 0) ? 16'($urandom) : id_pool[$urandom_range(3)];
  endfunction

  // Build a pair of touching regions with random content, then mostly test,
  // merge, replace and read them; some items are plain noise.
  task automatic region_scenario();
    int nt;
    int nc;
    logic [15:0] a;
    logic [15:0] b;
    a = id_pool[$urandom_range(1)];
    b = id_pool[2 + $urandom_range(1)];
    send_req(REQ_RESET, 0, 0, a, 0, 0, 0);
    send_req(REQ_RESET, 1, 0, b, 0, 0, 0);
    nt = $urandom_range(($urandom_range(7) == 0) ? 33 : 6);
    nc = $urandom_range(($urandom_range(7) == 0) ? 33 : 6);
    for (int i = 0; i < nt; i++)
      send_req(REQ_ADD_NB, 1, 0, (i == nt / 2) ? a : pick_id(), 0, 0, 0);
    for (int i = 0; i < nc; i++)
      send_req(REQ_ADD_NB, 0, 0, (i == nc / 2) ? b : pick_id(), 0, 0, 0);
    for (int i = $urandom_range(($urandom_range(5) == 0) ? 17 : 3); i > 0; i--)
      send_req(REQ_ADD_OV, 1'($urandom_range(1)), 0, pick_id(), 0, 0, 0);
    send_req(REQ_SPANS, 0, 0, 0, 0, ($urandom_range(3) == 0) ? 24'hFFFFFF : 24'($urandom), 0);
    send_req(REQ_SPANS, 1, 0, 0, 0, 24'($urandom), 0);
    for (int i = $urandom_range(6); i > 0; i--) begin
      case ($urandom_range(5))
        0, 1: send_req(REQ_TEST, 1'($urandom_range(1)), 0, 0, 0, 0, 0);
        2, 3: send_req(REQ_MERGE, 1'($urandom_range(1)), 0, 0, 0, 0, 0);
        4: send_req(REQ_REPLACE, 1'($urandom_range(1)), 0, pick_id(), pick_id(), 0, 0);
        default: send_req(REQ_READ, 1'($urandom_range(1)), 1'($urandom_range(1)), 0, 0, 0,
                          5'($urandom));
      endcase
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    sent_items = 0;
    phase_end = 0;
    held = 1'b0;
    id_pool = '{16'h0000, 16'hFFFF, 16'h5A5A, 16'hA5A5};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: a touching pair, duplicates, full lists, test/merge outcomes,
    // replace of a neighbour id, in- and out-of-range reads.
    send_req(REQ_RESET, 0, 0, 16'h0001, 0, 0, 0);
    send_req(REQ_RESET, 1, 0, 16'hFFFF, 0, 0, 0);
    send_req(REQ_MERGE, 1, 0, 0, 0, 0, 0);
    send_req(REQ_ADD_NB, 1, 0, 16'h0001, 0, 0, 0);
    send_req(REQ_ADD_NB, 1, 0, 16'h0007, 0, 0, 0);
    send_req(REQ_ADD_NB, 1, 0, 16'h0007, 0, 0, 0);
    send_req(REQ_ADD_NB, 0, 0, 16'hFFFF, 0, 0, 0);
    send_req(REQ_ADD_NB, 0, 0, 16'h0007, 0, 0, 0);
    send_req(REQ_ADD_OV, 0, 0, 16'h0000, 0, 0, 0);
    send_req(REQ_SPANS, 0, 0, 0, 0, 24'hFFFFFF, 0);
    send_req(REQ_SPANS, 1, 0, 0, 0, 24'h000001, 0);
    send_req(REQ_TEST, 1, 0, 0, 0, 0, 0);
    send_req(REQ_TEST, 0, 0, 0, 0, 0, 0);
    send_req(REQ_MERGE, 1, 0, 0, 0, 0, 0);
    send_req(REQ_READ, 1, 0, 0, 0, 0, 5'd0);
    send_req(REQ_READ, 1, 1, 0, 0, 0, 5'd0);
    send_req(REQ_READ, 1, 0, 0, 0, 0, 5'd31);
    send_req(REQ_REPLACE, 1, 0, 16'h0007, 16'h0000, 0, 0);
    send_req(REQ_ADD_OV, 1, 0, 16'h0001, 0, 0, 0);
    send_req(REQ_TEST, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 33; i++) send_req(REQ_ADD_NB, 0, 0, 16'($urandom), 0, 0, 0);
    for (int i = 0; i < 17; i++) send_req(REQ_ADD_OV, 0, 0, 16'($urandom), 0, 0, 0);
    send_req(REQ_MERGE, 0, 0, 0, 0, 0, 0);
    drain();

    // Random phases with the different idle and stall mixes.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 13 : 45) : 0;
      recv_stall_pct = (ph == 2) ? 45 : ((ph == 3) ? 13 : 0);
      phase_end = sent_items + 115;
      while (sent_items < phase_end) begin
        region_scenario();
        if (ph == 1 && !held && sent_items > phase_end - 80) begin
          drain();
          hold_cycles = 400;
          held = 1'b1;
        end
      end
      drain();
    end
    repeat (300) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
